/* rtl/periodic_task_scheduler_assert.svh */
// Assertion macros for the scheduler; clk and rst_n are taken from the using module.
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PTS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pts_pkg.sv */
`default_nettype none
package pts_pkg;

    parameter int TASKS_PER_LEVEL_DEF = 8;
    parameter int NUM_LEVELS          = 3;

    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_TICK     = 2'd1;
    localparam logic [1:0] ACT_THROTTLE = 2'd2;

    localparam logic [1:0] KIND_FIRED  = 2'd0;
    localparam logic [1:0] KIND_ADDED  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_ACK,
        ST_LVL,
        ST_LOW_DIFF,
        ST_LOW_CMP,
        ST_RD,
        ST_CMP,
        ST_UPD,
        ST_FIN
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic we_ivl;
        logic we_due;
    } mem_wr_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now;
        logic [1:0]  priority_level;
        logic [31:0] interval_ms;
        logic        start_now;
        logic        throttle_on;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic [1:0] level_out;
        logic [4:0] fired_count;
        logic       last;
    } res_t;

endpackage
`default_nettype wire

/* rtl/pts_alu.sv */
`default_nettype none
module pts_alu (
    input  pts_pkg::alu_op_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic [31:0]      sum,
    output logic             ge
);
    import pts_pkg::*;

    logic [31:0] b_op;
    logic [32:0] full;

    // subtract as a + ~b + 1; carry out means a >= b
    always_comb
    begin
        b_op = (op == ALU_SUB) ? ~b : b;
        full = {1'b0, a} + {1'b0, b_op} + {32'd0, (op == ALU_SUB)};
        sum  = full[31:0];
        ge   = full[32];
    end

endmodule
`default_nettype wire

/* rtl/pts_mem.sv */
`default_nettype none
module pts_mem #(
    parameter int DEPTH  = 24,
    parameter int ADDR_W = 5
) (
    input  logic               clk,
    input  logic [ADDR_W-1:0]  addr,
    input  pts_pkg::mem_wr_t   wr,
    input  logic [31:0]        ivl_wdata,
    input  logic [31:0]        due_wdata,
    output logic [31:0]        ivl_rdata,
    output logic [31:0]        due_rdata
);
    import pts_pkg::*;

    logic [31:0] ivl_mem [DEPTH];
    logic [31:0] due_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we_ivl)
        begin
            ivl_mem[addr] <= ivl_wdata;
        end
        if (wr.we_due)
        begin
            due_mem[addr] <= due_wdata;
        end
        ivl_rdata <= ivl_mem[addr];
        due_rdata <= due_mem[addr];
    end

endmodule
`default_nettype wire

/* rtl/periodic_task_scheduler.sv */
// Channel   Ports                       Handshake
// request   start, busy, request        accepted when start && !busy
// result    result_valid, result        one-cycle strobe, no back-pressure
// config    cfg_we, cfg_wdata           written when cfg_we
//
// Add, throttle and other actions: busy in ST_ADD or ST_ACK after accept, result strobe the cycle after.
// Tick: one shared 32-bit adder/comparator walks the used slots of each level
// (ST_LVL per level, then ST_RD and ST_CMP per slot, plus ST_UPD when it fires);
// ST_LOW_DIFF and ST_LOW_CMP check a throttled low level, and ST_FIN finishes.
// busy stays high for the whole request; the final result strobes as busy drops.
// Results cannot be stalled.
// Reset clears the slot counts, throttle state and skip interval; no clearing pass.
`default_nettype none
`include "periodic_task_scheduler_assert.svh"
module periodic_task_scheduler #(
    parameter int TASKS_PER_LEVEL = pts_pkg::TASKS_PER_LEVEL_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pts_pkg::req_t request,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    output logic          result_valid,
    output pts_pkg::res_t result
);
    import pts_pkg::*;

    localparam int NUM_SLOTS = NUM_LEVELS * TASKS_PER_LEVEL;
    localparam int ADDR_W    = $clog2(NUM_SLOTS);
    localparam int IDX_W     = (TASKS_PER_LEVEL > 1) ? $clog2(TASKS_PER_LEVEL) : 1;
    localparam int CNT_W     = $clog2(TASKS_PER_LEVEL + 1);

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [31:0]       skip_reg;
    logic              throttled_reg, throttled_next;
    logic [31:0]       last_low_reg, last_low_next;
    logic [CNT_W-1:0]  cnt_reg [NUM_LEVELS];
    logic [CNT_W-1:0]  cnt_next [NUM_LEVELS];
    logic [1:0]        lvl_reg, lvl_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       diff_reg, diff_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              pend_reg, pend_next;
    logic [4:0]        fired_reg, fired_next;
    logic              result_valid_reg;
    res_t              result_reg;

    logic [1:0]        sel_lvl;
    logic [CNT_W-1:0]  cnt_sel;
    logic [31:0]       slot_idx;
    logic [ADDR_W-1:0] addr;
    logic              add_valid;
    logic              add_ok;
    logic              lvl_last;
    alu_op_t           alu_op;
    logic [31:0]       alu_a, alu_b, alu_sum;
    logic              alu_ge;
    mem_wr_t           mem_wr;
    logic [31:0]       due_wdata;
    logic [31:0]       ivl_rd, due_rd;
    logic              emit;
    res_t              emit_res;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign sel_lvl = (state_reg == ST_ADD) ? req_reg.priority_level : lvl_reg;

    always_comb
    begin
        unique case (sel_lvl)
            LVL_HIGH: cnt_sel = cnt_reg[0];
            LVL_MED:  cnt_sel = cnt_reg[1];
            LVL_LOW:  cnt_sel = cnt_reg[2];
            default:  cnt_sel = '0;
        endcase
    end

    assign add_valid = (req_reg.priority_level <= LVL_LOW);
    assign add_ok    = add_valid && (cnt_sel != CNT_W'(TASKS_PER_LEVEL));
    assign slot_idx  = (state_reg == ST_ADD) ? 32'(cnt_sel) : 32'(idx_reg);
    assign addr      = ADDR_W'(32'(sel_lvl) * TASKS_PER_LEVEL + slot_idx);
    assign lvl_last  = ((32'(idx_reg) + 32'd1) == 32'(cnt_sel));

    pts_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    pts_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk       (clk),
        .addr      (addr),
        .wr        (mem_wr),
        .ivl_wdata (req_reg.interval_ms),
        .due_wdata (due_wdata),
        .ivl_rdata (ivl_rd),
        .due_rdata (due_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (request.action == ACT_ADD)
                        state_next = ST_ADD;
                    else if (request.action == ACT_TICK)
                        state_next = ST_LVL;
                    else
                        state_next = ST_ACK;
                end
            end
            ST_ADD, ST_ACK, ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            ST_LVL:
            begin
                if (cnt_sel == '0)
                    state_next = (lvl_reg == LVL_LOW) ? ST_FIN : ST_LVL;
                else if (lvl_reg == LVL_LOW && throttled_reg)
                    state_next = ST_LOW_DIFF;
                else
                    state_next = ST_RD;
            end
            ST_LOW_DIFF:
            begin
                state_next = ST_LOW_CMP;
            end
            ST_LOW_CMP:
            begin
                state_next = alu_ge ? ST_RD : ST_FIN;
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP, ST_UPD:
            begin
                if (state_reg == ST_CMP && alu_ge)
                    state_next = ST_UPD;
                else if (!lvl_last)
                    state_next = ST_RD;
                else
                    state_next = (lvl_reg == LVL_LOW) ? ST_FIN : ST_LVL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next        = req_reg;
        throttled_next  = throttled_reg;
        last_low_next   = last_low_reg;
        cnt_next        = cnt_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        diff_next       = diff_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        fired_next      = fired_reg;
        alu_op          = ALU_ADD;
        alu_a           = req_reg.now;
        alu_b           = req_reg.interval_ms;
        mem_wr          = '0;
        due_wdata       = alu_sum;
        emit            = 1'b0;
        emit_res        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next        = request;
                    lvl_next        = LVL_HIGH;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    fired_next      = '0;
                end
            end
            ST_ADD:
            begin
                emit          = 1'b1;
                emit_res.last = 1'b1;
                if (add_ok)
                begin
                    mem_wr.we_ivl      = 1'b1;
                    mem_wr.we_due      = 1'b1;
                    due_wdata          = req_reg.start_now ? req_reg.now : alu_sum;
                    emit_res.kind      = KIND_ADDED;
                    emit_res.slot      = 3'(cnt_sel);
                    emit_res.level_out = req_reg.priority_level;
                    cnt_next[sel_lvl]  = cnt_sel + 1'b1;
                end
                else
                begin
                    emit_res.kind      = KIND_REJECT;
                    emit_res.level_out = add_valid ? req_reg.priority_level : LVL_HIGH;
                end
            end
            ST_ACK:
            begin
                emit          = 1'b1;
                emit_res.kind = KIND_NONE;
                emit_res.last = 1'b1;
                if (req_reg.action == ACT_THROTTLE)
                begin
                    if (!throttled_reg && req_reg.throttle_on)
                        last_low_next = req_reg.now;
                    throttled_next = req_reg.throttle_on;
                end
            end
            ST_LVL:
            begin
                idx_next = '0;
                if (cnt_sel == '0)
                    lvl_next = lvl_reg + 1'b1;
                else if (lvl_reg == LVL_LOW && !throttled_reg)
                    last_low_next = req_reg.now;
            end
            ST_LOW_DIFF:
            begin
                alu_op    = ALU_SUB;
                alu_b     = last_low_reg;
                diff_next = alu_sum;
            end
            ST_LOW_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = diff_reg;
                alu_b  = skip_reg;
                if (alu_ge)
                    last_low_next = req_reg.now;
            end
            ST_RD:
            begin
            end
            ST_CMP, ST_UPD:
            begin
                alu_op = (state_reg == ST_CMP) ? ALU_SUB : ALU_ADD;
                alu_b  = (state_reg == ST_CMP) ? due_rd : ivl_rd;
                if (state_reg == ST_UPD)
                begin
                    // hold each firing back one step so the final one can carry last
                    mem_wr.we_due         = 1'b1;
                    fired_next            = fired_reg + 1'b1;
                    pend_valid_next       = 1'b1;
                    pend_next.kind        = KIND_FIRED;
                    pend_next.slot        = 3'(idx_reg);
                    pend_next.level_out   = lvl_reg;
                    pend_next.fired_count = fired_reg + 1'b1;
                    pend_next.last        = 1'b0;
                    emit                  = pend_valid_reg;
                    emit_res              = pend_reg;
                end
                if (state_reg == ST_UPD || !alu_ge)
                begin
                    if (lvl_last)
                    begin
                        idx_next = '0;
                        lvl_next = lvl_reg + 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                emit = 1'b1;
                if (pend_valid_reg)
                begin
                    emit_res      = pend_reg;
                    emit_res.last = 1'b1;
                end
                else
                begin
                    emit_res.kind = KIND_NONE;
                    emit_res.last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            skip_reg         <= '0;
            throttled_reg    <= 1'b0;
            last_low_reg     <= '0;
            lvl_reg          <= '0;
            idx_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            fired_reg        <= '0;
            result_valid_reg <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                cnt_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            throttled_reg    <= throttled_next;
            last_low_reg     <= last_low_next;
            lvl_reg          <= lvl_next;
            idx_reg          <= idx_next;
            pend_valid_reg   <= pend_valid_next;
            fired_reg        <= fired_next;
            result_valid_reg <= emit;
            cnt_reg          <= cnt_next;
            if (cfg_we)
            begin
                skip_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        diff_reg   <= diff_next;
        pend_reg   <= pend_next;
        result_reg <= emit_res;
    end

    `PTS_ASSERT_IMP(a_nonfire_is_last, result_valid && result.kind != KIND_FIRED, result.last, "non-firing result without last")
    `PTS_ASSERT_IMP(a_fire_counted, result_valid && result.kind == KIND_FIRED, result.fired_count != 5'd0, "firing with zero count")
    `PTS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `PTS_ASSERT_IMP(a_last_idle, result_valid && result.last, !busy, "busy after final result")
    `PTS_ASSERT_IMP(a_cnt_bound, 1'b1, (cnt_reg[0] <= CNT_W'(TASKS_PER_LEVEL)) && (cnt_reg[1] <= CNT_W'(TASKS_PER_LEVEL)) && (cnt_reg[2] <= CNT_W'(TASKS_PER_LEVEL)), "slot count overflow")

endmodule
`default_nettype wire
